/* hw/rtl/wall_segment_projection_assert.svh */
// Assertion macros for the wall segment projection block.
`ifndef WALL_SEGMENT_PROJECTION_ASSERT_SVH
`define WALL_SEGMENT_PROJECTION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wsp_pkg.sv */
// Shared types and constants for the wall segment projection block.
package wsp_pkg;

  localparam int SCREEN_W_DEF = 160;
  localparam int SCREEN_H_DEF = 120;

  localparam int CW   = 20;  // view-space coordinate width
  localparam int DW   = 19;  // depth width once clamped to at least one
  localparam int FW   = 16;  // clip factor bits
  localparam int CDW  = 21;  // clip divisor width
  localparam int CSTP = 4;   // clip divider steps per stage
  localparam int PNW  = 30;  // projection numerator magnitude width
  localparam int PSTP = 5;   // projection divider steps per stage

  localparam logic signed [15:0] COS_RST   = 16'sd16384;
  localparam logic [9:0]         SCALE_RST = 10'd200;
  localparam logic [9:0]         RISE_RST  = 10'd40;

  typedef enum logic [2:0] {
    CFG_CAM_X = 3'd0,
    CFG_CAM_Y = 3'd1,
    CFG_CAM_Z = 3'd2,
    CFG_COS   = 3'd3,
    CFG_SIN   = 3'd4,
    CFG_SCALE = 3'd5,
    CFG_RISE  = 3'd6
  } wsp_cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic [3:0]         wall_color;
  } wsp_in_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x_start;
    logic signed [15:0] screen_x_end;
    logic signed [15:0] bottom_y_start;
    logic signed [15:0] bottom_y_end;
    logic signed [15:0] top_y_start;
    logic signed [15:0] top_y_end;
    logic [3:0]         out_color;
  } wsp_out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] zb;
    logic signed [CW-1:0] zt;
  } wsp_pt_t;

  typedef struct packed {
    logic       behind;
    logic       clip_a;
    logic       clip_b;
    logic [3:0] color;
    wsp_pt_t    a;
    wsp_pt_t    b;
  } wsp_ctag_t;

endpackage

/* hw/rtl/wsp_div.sv */
// Pipelined restoring divider, STEPS quotient bits per stage (fewer in the last when Q_W is not a multiple of STEPS).
module wsp_div #(
  parameter int DEN_W = 8,
  parameter int Q_W   = 8,
  parameter int STEPS = 4,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [Q_W-1:0]   in_bits,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quot,
  output logic [TAG_W-1:0] out_tag
);
  localparam int NSTG = (Q_W + STEPS - 1) / STEPS;

  logic             vld_r [NSTG];
  logic [DEN_W-1:0] rem_r [NSTG];
  logic [Q_W-1:0]   w_r   [NSTG];
  logic [DEN_W-1:0] den_r [NSTG];
  logic [TAG_W-1:0] tag_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   w_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W-1:0] rem_nxt;
    logic [Q_W-1:0]   w_nxt;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_rem;
      assign w_in   = in_bits;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_rest
      assign v_in   = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign w_in   = w_r[s-1];
      assign den_in = den_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    // remainder stays below the divisor; quotient bits shift in behind the dividend
    always_comb begin
      logic [DEN_W:0] r2;
      r2      = '0;
      rem_nxt = rem_in;
      w_nxt   = w_in;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < Q_W) begin
          r2    = {rem_nxt, w_nxt[Q_W-1]};
          w_nxt = {w_nxt[Q_W-2:0], 1'b0};
          if (r2 >= {1'b0, den_in}) begin
            r2       = r2 - {1'b0, den_in};
            w_nxt[0] = 1'b1;
          end
          rem_nxt = r2[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      w_r[s]   <= w_nxt;
      den_r[s] <= den_in;
      tag_r[s] <= tag_in;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_quot  = w_r[NSTG-1];
  assign out_tag   = tag_r[NSTG-1];

endmodule

/* hw/rtl/wsp_transform.sv */
// Camera translation and view rotation of both endpoints, two stages.
module wsp_transform (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  wsp_pkg::wsp_in_t      in_item,
  input  logic signed [15:0]    cam_x,
  input  logic signed [15:0]    cam_y,
  input  logic signed [15:0]    cam_z,
  input  logic signed [15:0]    view_cos,
  input  logic signed [15:0]    view_sin,
  input  logic [9:0]            rise,
  output logic                  out_valid,
  output wsp_pkg::wsp_pt_t      out_a,
  output wsp_pkg::wsp_pt_t      out_b,
  output logic [3:0]            out_color
);
  import wsp_pkg::*;

  logic signed [16:0] dx [2];
  logic signed [16:0] dy [2];
  logic signed [16:0] dz [2];
  logic signed [32:0] xc_nxt [2];
  logic signed [32:0] ys_nxt [2];
  logic signed [32:0] yc_nxt [2];
  logic signed [32:0] xs_nxt [2];

  logic               v1_r;
  logic signed [32:0] xc_r [2];
  logic signed [32:0] ys_r [2];
  logic signed [32:0] yc_r [2];
  logic signed [32:0] xs_r [2];
  logic signed [16:0] zb_r [2];
  logic [3:0]         col_r;

  wsp_pt_t pt_nxt [2];
  logic    v2_r;
  wsp_pt_t a_r;
  wsp_pt_t b_r;
  logic [3:0] col2_r;

  always_comb begin
    dx[0] = {in_item.start_x[15], in_item.start_x} - {cam_x[15], cam_x};
    dy[0] = {in_item.start_y[15], in_item.start_y} - {cam_y[15], cam_y};
    dz[0] = {in_item.start_z[15], in_item.start_z} - {cam_z[15], cam_z};
    dx[1] = {in_item.end_x[15], in_item.end_x} - {cam_x[15], cam_x};
    dy[1] = {in_item.end_y[15], in_item.end_y} - {cam_y[15], cam_y};
    dz[1] = {in_item.end_z[15], in_item.end_z} - {cam_z[15], cam_z};
    for (int i = 0; i < 2; i++) begin
      xc_nxt[i] = dx[i] * view_cos;
      ys_nxt[i] = dy[i] * view_sin;
      yc_nxt[i] = dy[i] * view_cos;
      xs_nxt[i] = dx[i] * view_sin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      xc_r[i] <= xc_nxt[i];
      ys_r[i] <= ys_nxt[i];
      yc_r[i] <= yc_nxt[i];
      xs_r[i] <= xs_nxt[i];
    end
    zb_r[0] <= dz[0];
    zb_r[1] <= dz[1];
    col_r   <= in_item.wall_color;
  end

  // Q2.14 products back to integers, rounded toward zero
  always_comb begin
    logic signed [33:0] sx;
    logic signed [33:0] sy;
    logic signed [CW-1:0] zb;
    for (int i = 0; i < 2; i++) begin
      sx = {xc_r[i][32], xc_r[i]} - {ys_r[i][32], ys_r[i]};
      sy = {yc_r[i][32], yc_r[i]} + {xs_r[i][32], xs_r[i]};
      sx = sx + (sx[33] ? 34'sd16383 : 34'sd0);
      sy = sy + (sy[33] ? 34'sd16383 : 34'sd0);
      zb = {{(CW-17){zb_r[i][16]}}, zb_r[i]};
      pt_nxt[i].x  = sx[33:14];
      pt_nxt[i].y  = sy[33:14];
      pt_nxt[i].zb = zb;
      pt_nxt[i].zt = zb + $signed({{(CW-10){1'b0}}, rise});
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= pt_nxt[0];
    b_r    <= pt_nxt[1];
    col2_r <= col_r;
  end

  assign out_valid = v2_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_color = col2_r;

endmodule

/* hw/rtl/wsp_clip.sv */
// Near-plane clip: factor divider, then interpolation over two stages.
module wsp_clip (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  wsp_pkg::wsp_pt_t in_a,
  input  wsp_pkg::wsp_pt_t in_b,
  input  logic [3:0]       in_color,
  output logic             out_valid,
  output wsp_pkg::wsp_pt_t out_a,
  output wsp_pkg::wsp_pt_t out_b,
  output logic             out_behind,
  output logic [3:0]       out_color
);
  import wsp_pkg::*;

  localparam int TAG_W = $bits(wsp_ctag_t);

  wsp_ctag_t        tag_in;
  logic [CDW-1:0]   rem0;
  logic [CDW-1:0]   den;
  logic             dv_valid;
  logic [FW-1:0]    dv_quot;
  logic [TAG_W-1:0] dv_tag_bits;
  wsp_ctag_t        dv_tag;

  logic signed [CW-1:0]     nc [4];
  logic signed [CW-1:0]     fc [4];
  logic signed [CW+17:0]    prod_nxt [4];

  logic                     l1_valid_r;
  logic signed [CW+17:0]    prod_r [4];
  wsp_ctag_t                l1_tag_r;

  logic signed [CW-1:0]     lc [4];
  wsp_pt_t                  np;
  wsp_pt_t                  a_nxt;
  wsp_pt_t                  b_nxt;

  logic                     valid_r;
  wsp_pt_t                  a_r;
  wsp_pt_t                  b_r;
  logic                     behind_r;
  logic [3:0]               color_r;

  always_comb begin
    logic signed [CW-1:0] negy;
    wsp_pt_t near;
    wsp_pt_t far;
    tag_in.clip_a = in_a.y[CW-1] || (in_a.y == '0);
    tag_in.clip_b = in_b.y[CW-1] || (in_b.y == '0);
    tag_in.behind = tag_in.clip_a && tag_in.clip_b;
    tag_in.color  = in_color;
    tag_in.a      = in_a;
    tag_in.b      = in_b;
    near = tag_in.clip_a ? in_a : in_b;
    far  = tag_in.clip_a ? in_b : in_a;
    negy = -near.y;
    if ((tag_in.clip_a || tag_in.clip_b) && !tag_in.behind) begin
      rem0 = CDW'(unsigned'(negy));
      den  = CDW'(unsigned'(negy)) + CDW'(unsigned'(far.y));
    end else begin
      rem0 = '0;
      den  = CDW'(1);
    end
  end

  wsp_div #(
    .DEN_W (CDW),
    .Q_W   (FW),
    .STEPS (CSTP),
    .TAG_W (TAG_W)
  ) u_fdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_rem    (rem0),
    .in_bits   ('0),
    .in_den    (den),
    .in_tag    (tag_in),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_tag   (dv_tag_bits)
  );

  assign dv_tag = wsp_ctag_t'(dv_tag_bits);

  always_comb begin
    wsp_pt_t near;
    wsp_pt_t far;
    logic signed [CW:0] diff;
    near = dv_tag.clip_a ? dv_tag.a : dv_tag.b;
    far  = dv_tag.clip_a ? dv_tag.b : dv_tag.a;
    nc[0] = near.x;  fc[0] = far.x;
    nc[1] = near.y;  fc[1] = far.y;
    nc[2] = near.zb; fc[2] = far.zb;
    nc[3] = near.zt; fc[3] = far.zt;
    for (int i = 0; i < 4; i++) begin
      diff        = {fc[i][CW-1], fc[i]} - {nc[i][CW-1], nc[i]};
      prod_nxt[i] = $signed({1'b0, dv_quot}) * diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      l1_valid_r <= dv_valid;
      valid_r    <= l1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
    l1_tag_r <= dv_tag;
  end

  // Q16 step toward the far point, truncated toward zero
  always_comb begin
    wsp_pt_t near;
    logic signed [CW+17:0] t;
    near  = l1_tag_r.clip_a ? l1_tag_r.a : l1_tag_r.b;
    lc[0] = near.x;
    lc[1] = near.y;
    lc[2] = near.zb;
    lc[3] = near.zt;
    for (int i = 0; i < 4; i++) begin
      t     = prod_r[i] + (prod_r[i][CW+17] ? (CW+18)'(65535) : '0);
      lc[i] = lc[i] + t[CW+15:16];
    end
    np.x  = lc[0];
    np.y  = (lc[1][CW-1] || (lc[1] == '0)) ? CW'(1) : lc[1];
    np.zb = lc[2];
    np.zt = lc[3];
    a_nxt = (l1_tag_r.clip_a && !l1_tag_r.behind) ? np : l1_tag_r.a;
    b_nxt = (l1_tag_r.clip_b && !l1_tag_r.behind) ? np : l1_tag_r.b;
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    behind_r <= l1_tag_r.behind;
    color_r  <= l1_tag_r.color;
  end

  assign out_valid  = valid_r;
  assign out_a      = a_r;
  assign out_b      = b_r;
  assign out_behind = behind_r;
  assign out_color  = color_r;

endmodule

/* hw/rtl/wsp_project.sv */
// Scaling, perspective divide, centring, saturation and visibility test.
module wsp_project #(
  parameter int SCREEN_W = wsp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = wsp_pkg::SCREEN_H_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  wsp_pkg::wsp_pt_t in_a,
  input  wsp_pkg::wsp_pt_t in_b,
  input  logic             in_behind,
  input  logic [3:0]       in_color,
  input  logic [9:0]       scale,
  output logic             out_strobe,
  output wsp_pkg::wsp_out_t out_item
);
  import wsp_pkg::*;

  localparam int CEN_X = SCREEN_W / 2;
  localparam int CEN_Y = SCREEN_H / 2;
  localparam logic signed [31:0] XMAX = 32'(SCREEN_W - 1);
  localparam int TAG_W = 6;

  logic signed [CW-1:0] v [6];
  logic [DW-1:0]        dep [6];

  logic                 p1_valid_r;
  logic signed [CW+10:0] prod_r [6];
  logic [DW-1:0]        dep_r [6];
  logic                 behind_r;
  logic [3:0]           color_r;

  logic                 dv_valid [6];
  logic [PNW-1:0]       dv_quot [6];
  logic [TAG_W-1:0]     dv_tag [6];

  logic signed [31:0]   res [6];
  wsp_out_t             item_nxt;
  logic                 strobe_r;
  wsp_out_t             item_r;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
    if (x > 32'sd32767) begin
      return 16'sh7fff;
    end else if (x < -32'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  always_comb begin
    v[0] = in_a.x;  v[1] = in_b.x;
    v[2] = in_a.zb; v[3] = in_b.zb;
    v[4] = in_a.zt; v[5] = in_b.zt;
    for (int i = 0; i < 6; i++) begin
      dep[i] = (i % 2 == 0) ? in_a.y[DW-1:0] : in_b.y[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      p1_valid_r <= in_valid;
      strobe_r   <= dv_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod_r[i] <= v[i] * $signed({1'b0, scale});
      dep_r[i]  <= dep[i];
    end
    behind_r <= in_behind;
    color_r  <= in_color;
  end

  for (genvar i = 0; i < 6; i++) begin : g_div
    logic               sgn;
    logic signed [CW+10:0] mag;
    logic [TAG_W-1:0]   tag;
    logic [PNW-1:0]     q;
    logic signed [31:0] qs;

    assign sgn = prod_r[i][CW+10];
    assign mag = sgn ? -prod_r[i] : prod_r[i];
    if (i == 0) begin : g_lead
      assign tag = {sgn, behind_r, color_r};
    end else begin : g_other
      assign tag = {sgn, 5'b0};
    end

    wsp_div #(
      .DEN_W (DW),
      .Q_W   (PNW),
      .STEPS (PSTP),
      .TAG_W (TAG_W)
    ) u_pdiv (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (p1_valid_r),
      .in_rem    ('0),
      .in_bits   (mag[PNW-1:0]),
      .in_den    (dep_r[i]),
      .in_tag    (tag),
      .out_valid (dv_valid[i]),
      .out_quot  (dv_quot[i]),
      .out_tag   (dv_tag[i])
    );

    assign q  = dv_quot[i];
    assign qs = dv_tag[i][TAG_W-1] ? -$signed({2'b0, q}) : $signed({2'b0, q});
    assign res[i] = qs + ((i < 2) ? 32'(CEN_X) : 32'(CEN_Y));
  end

  always_comb begin
    logic vis;
    vis = !dv_tag[0][4]
          && !((res[0] < 32'sd1) && (res[1] < 32'sd1))
          && !((res[0] > XMAX) && (res[1] > XMAX));
    item_nxt.visible        = vis;
    item_nxt.screen_x_start = vis ? sat16(res[0]) : '0;
    item_nxt.screen_x_end   = vis ? sat16(res[1]) : '0;
    item_nxt.bottom_y_start = vis ? sat16(res[2]) : '0;
    item_nxt.bottom_y_end   = vis ? sat16(res[3]) : '0;
    item_nxt.top_y_start    = vis ? sat16(res[4]) : '0;
    item_nxt.top_y_end      = vis ? sat16(res[5]) : '0;
    item_nxt.out_color      = dv_tag[0][3:0];
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

/* hw/rtl/wall_segment_projection.sv */
// Top level of the wall segment projection block.
// One wall enters per clock (busy stays low) and its result leaves on out_strobe
// after two rotation stages, the four-stage near-clip factor
// divider with two interpolation stages, and the scale stage, six-stage
// perspective divider and output register. The receiver cannot stall; results
// must be taken on the strobe cycle. Configuration writes are always accepted
// and apply to walls already in flight, so write only between frames.
`include "wall_segment_projection_assert.svh"

module wall_segment_projection #(
  parameter int SCREEN_W = wsp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = wsp_pkg::SCREEN_H_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wsp_pkg::wsp_in_t  in_item,
  output logic              out_strobe,
  output wsp_pkg::wsp_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import wsp_pkg::*;

  logic signed [15:0] cam_x_r;
  logic signed [15:0] cam_y_r;
  logic signed [15:0] cam_z_r;
  logic signed [15:0] cos_r;
  logic signed [15:0] sin_r;
  logic [9:0]         scale_r;
  logic [9:0]         rise_r;

  logic    xf_valid;
  wsp_pt_t xf_a;
  wsp_pt_t xf_b;
  logic [3:0] xf_color;

  logic    cl_valid;
  wsp_pt_t cl_a;
  wsp_pt_t cl_b;
  logic    cl_behind;
  logic [3:0] cl_color;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      cos_r   <= COS_RST;
      sin_r   <= '0;
      scale_r <= SCALE_RST;
      rise_r  <= RISE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wsp_cfg_idx_t'(cfg_index))
        CFG_CAM_X: cam_x_r <= cfg_data;
        CFG_CAM_Y: cam_y_r <= cfg_data;
        CFG_CAM_Z: cam_z_r <= cfg_data;
        CFG_COS:   cos_r   <= cfg_data;
        CFG_SIN:   sin_r   <= cfg_data;
        CFG_SCALE: scale_r <= cfg_data[9:0];
        CFG_RISE:  rise_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  wsp_transform u_xf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (in_item),
    .cam_x     (cam_x_r),
    .cam_y     (cam_y_r),
    .cam_z     (cam_z_r),
    .view_cos  (cos_r),
    .view_sin  (sin_r),
    .rise      (rise_r),
    .out_valid (xf_valid),
    .out_a     (xf_a),
    .out_b     (xf_b),
    .out_color (xf_color)
  );

  wsp_clip u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (xf_valid),
    .in_a       (xf_a),
    .in_b       (xf_b),
    .in_color   (xf_color),
    .out_valid  (cl_valid),
    .out_a      (cl_a),
    .out_b      (cl_b),
    .out_behind (cl_behind),
    .out_color  (cl_color)
  );

  wsp_project #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_proj (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cl_valid),
    .in_a       (cl_a),
    .in_b       (cl_b),
    .in_behind  (cl_behind),
    .in_color   (cl_color),
    .scale      (scale_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  `WSP_ASSERT_IMP(a_hidden_zero, out_strobe && !out_item.visible, out_item.screen_x_start == '0 && out_item.screen_x_end == '0 && out_item.bottom_y_start == '0 && out_item.bottom_y_end == '0 && out_item.top_y_start == '0 && out_item.top_y_end == '0, "hidden wall item carries coordinates")
  `WSP_ASSERT_IMP(a_vis_left, out_strobe && out_item.visible, !(out_item.screen_x_start < 16'sd1 && out_item.screen_x_end < 16'sd1), "visible wall lies left of screen")
  `WSP_ASSERT_IMP(a_xf_lat, start && !busy, ##2 xf_valid, "accepted item lost in rotation stages")
  `WSP_ASSERT_NEXT(a_cfg_scale, cfg_valid && cfg_ready && cfg_index == CFG_SCALE, scale_r == $past(cfg_data[9:0]), "scale write not taken")

endmodule
